// ===== rtl/core/hrt_pkg.sv =====
// Shared types, constants and lookup functions for the HTTP request header tokenizer.
package hrt_pkg;

  typedef enum logic [3:0] {
    PH_METHOD = 4'd0,
    PH_PATH   = 4'd1,
    PH_PREFIX = 4'd2,
    PH_MAJOR  = 4'd3,
    PH_DOT    = 4'd4,
    PH_MINOR  = 4'd5,
    PH_WSKEY  = 4'd6,
    PH_KEY    = 4'd7,
    PH_WSVAL  = 4'd8,
    PH_VALUE  = 4'd9,
    PH_END1   = 4'd10,
    PH_END2   = 4'd11,
    PH_BODY   = 4'd12
  } phase_t;

  typedef enum logic [3:0] {
    TK_NONE       = 4'd0,
    TK_METHOD     = 4'd1,
    TK_PATH_BYTE  = 4'd2,
    TK_PATH_END   = 4'd3,
    TK_VERSION    = 4'd4,
    TK_KEY_BYTE   = 4'd5,
    TK_KEY_END    = 4'd6,
    TK_VALUE_BYTE = 4'd7,
    TK_VALUE_END  = 4'd8,
    TK_HEADER_END = 4'd9,
    TK_BODY       = 4'd10
  } kind_t;

  localparam logic [2:0] MC_UNKNOWN = 3'd0;
  localparam logic [2:0] MC_GET     = 3'd1;
  localparam logic [2:0] MC_POST    = 3'd2;
  localparam logic [2:0] MC_DELETE  = 3'd3;
  localparam logic [2:0] MC_PUT     = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [7:0] MIN_LEN_RESET  = 8'd22;
  localparam logic [2:0] PREFIX_BYTES   = 3'd5;
  localparam logic [3:0] METHOD_LEN_SAT = 4'd10;
  localparam int         NUM_METHODS    = 4;

  typedef struct packed {
    logic       last;
    logic       done;
    logic [1:0] status;
    logic [7:0] minor;
    logic [7:0] major;
    logic [2:0] code;
    logic [7:0] data;
    kind_t      kind;
  } result_t;

  // Character of method m at position pos; zero beyond the method's length
  function automatic logic [7:0] method_char(input logic [1:0] m, input logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (m)
      2'd0: begin
        case (pos)
          4'd0: c = "G";
          4'd1: c = "E";
          4'd2: c = "T";
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          4'd0: c = "P";
          4'd1: c = "O";
          4'd2: c = "S";
          4'd3: c = "T";
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          4'd0: c = "D";
          4'd1: c = "E";
          4'd2: c = "L";
          4'd3: c = "E";
          4'd4: c = "T";
          4'd5: c = "E";
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          4'd0: c = "P";
          4'd1: c = "U";
          4'd2: c = "T";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [3:0] method_len(input logic [1:0] m);
    logic [3:0] l;
    case (m)
      2'd0:    l = 4'd3;
      2'd1:    l = 4'd4;
      2'd2:    l = 4'd6;
      default: l = 4'd3;
    endcase
    return l;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_LF) || (b == CH_CR) || (b == CH_TAB);
  endfunction

  function automatic result_t mk_result(input kind_t k, input logic [7:0] d,
                                        input logic [2:0] c, input logic [7:0] mj,
                                        input logic [7:0] mn);
    result_t r;
    r        = '0;
    r.kind   = k;
    r.data   = d;
    r.code   = c;
    r.major  = mj;
    r.minor  = mn;
    return r;
  endfunction

endpackage

// ===== rtl/core/http_request_header_tokenizer.sv =====
// Top level of the HTTP request header tokenizer: byte stream in, token stream out.
//
//  Channel   Signals                                Transaction
//  s_axis    tvalid tready tdata[7:0] tlast         one request byte; tlast ends the request
//  m_axis    tvalid tready tdata[31:0] tuser tlast  one token; tlast on final token of a byte
//  cfg       cfg_valid cfg_ready cfg_data[7:0]      write of the minimum request length
//
// One byte is accepted per cycle while s_axis_tready is high; its tokens (up to two) enter the
// output queue at the same edge and leave one per cycle while m_axis_tready is high.
// s_axis_tready is high while the four-entry queue has room for two tokens: it drops under
// m_axis_tready back-pressure, and for a cycle when back-to-back two-token bytes fill it.
// rst is synchronous; it clears the parse state, empties the queue and restores the
// minimum length of 22. cfg_ready is always high.
module http_request_header_tokenizer #(
  parameter int OUT_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_request
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] token_byte, [10:8] method_code, [18:11] version_major,
  // [26:19] version_minor, [28:27] request_status, [29] request_done, [31:30] zero
  output logic [31:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
  output logic        m_axis_tlast,   // last_result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic             take;
  logic [1:0]       res_count;
  hrt_pkg::result_t res0;
  hrt_pkg::result_t res1;
  hrt_pkg::result_t head;
  logic             room_two;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = room_two;
  assign take          = s_axis_tvalid && room_two;

  hrt_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_take   (take),
    .in_byte   (s_axis_tdata),
    .in_end    (s_axis_tlast),
    .res_count (res_count),
    .res0      (res0),
    .res1      (res1)
  );

  hrt_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_count (take ? res_count : 2'd0),
    .wr0      (res0),
    .wr1      (res1),
    .room_two (room_two),
    .rd_valid (m_axis_tvalid),
    .rd_data  (head),
    .rd_ready (m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, head.done, head.status, head.minor, head.major,
                         head.code, head.data};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

// ===== rtl/core/hrt_parser.sv =====
// Parse state registers and the per-byte token logic, up to two results per byte.
module hrt_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_data,
  input  logic              in_take,
  input  logic [7:0]        in_byte,
  input  logic              in_end,
  output logic [1:0]        res_count,
  output hrt_pkg::result_t  res0,
  output hrt_pkg::result_t  res1
);

  logic [7:0]       min_len;
  hrt_pkg::phase_t  phase, phase_next;
  logic [2:0]       skip_cnt, skip_cnt_next;
  logic [3:0]       match, match_next;
  logic [3:0]       mlen, mlen_next;
  logic [7:0]       major, major_next;
  logic [7:0]       minor, minor_next;
  logic             held_cr, held_cr_next;
  logic [7:0]       seen, seen_next;

  hrt_pkg::result_t tok [2];
  logic [1:0]       n;
  logic             do_key;
  logic             do_value;
  logic [2:0]       code;

  always_comb begin
    phase_next    = phase;
    skip_cnt_next = skip_cnt;
    match_next    = match;
    mlen_next     = mlen;
    major_next    = major;
    minor_next    = minor;
    held_cr_next  = held_cr;
    seen_next     = (seen != 8'hFF) ? seen + 8'd1 : seen;
    tok[0]        = '0;
    tok[1]        = '0;
    n             = 2'd0;
    do_key        = 1'b0;
    do_value      = 1'b0;
    code          = hrt_pkg::MC_UNKNOWN;

    unique case (phase)
      hrt_pkg::PH_METHOD: begin
        if (in_byte == hrt_pkg::CH_SP) begin
          // later entries win, as in the matching order
          for (int i = 0; i < hrt_pkg::NUM_METHODS; i++) begin
            if (match[i] && mlen == hrt_pkg::method_len(2'(i))) code = 3'(i + 1);
          end
          tok[n[0]]  = hrt_pkg::mk_result(hrt_pkg::TK_METHOD, 8'd0, code, 8'd0, 8'd0);
          n          = n + 2'd1;
          phase_next = hrt_pkg::PH_PATH;
        end else begin
          for (int i = 0; i < hrt_pkg::NUM_METHODS; i++) begin
            if (mlen >= hrt_pkg::method_len(2'(i)) ||
                hrt_pkg::method_char(2'(i), mlen) != in_byte) match_next[i] = 1'b0;
          end
          if (mlen < hrt_pkg::METHOD_LEN_SAT) mlen_next = mlen + 4'd1;
        end
      end
      hrt_pkg::PH_PATH: begin
        if (in_byte == hrt_pkg::CH_SP) begin
          tok[n[0]]     = hrt_pkg::mk_result(hrt_pkg::TK_PATH_END, 8'd0, 3'd0, 8'd0, 8'd0);
          n             = n + 2'd1;
          phase_next    = hrt_pkg::PH_PREFIX;
          skip_cnt_next = 3'd0;
        end else begin
          tok[n[0]] = hrt_pkg::mk_result(hrt_pkg::TK_PATH_BYTE, in_byte, 3'd0, 8'd0, 8'd0);
          n         = n + 2'd1;
        end
      end
      hrt_pkg::PH_PREFIX: begin
        skip_cnt_next = skip_cnt + 3'd1;
        if (skip_cnt_next >= hrt_pkg::PREFIX_BYTES) phase_next = hrt_pkg::PH_MAJOR;
      end
      hrt_pkg::PH_MAJOR: begin
        major_next = in_byte - hrt_pkg::CH_ZERO;
        phase_next = hrt_pkg::PH_DOT;
      end
      hrt_pkg::PH_DOT: begin
        if (in_byte == hrt_pkg::CH_DOT) begin
          phase_next = hrt_pkg::PH_MINOR;
        end else begin
          minor_next = 8'd0;
          tok[n[0]]  = hrt_pkg::mk_result(hrt_pkg::TK_VERSION, 8'd0, 3'd0, major, 8'd0);
          n          = n + 2'd1;
          phase_next = hrt_pkg::PH_WSKEY;
        end
      end
      hrt_pkg::PH_MINOR: begin
        minor_next = in_byte - hrt_pkg::CH_ZERO;
        tok[n[0]]  = hrt_pkg::mk_result(hrt_pkg::TK_VERSION, 8'd0, 3'd0, major, minor_next);
        n          = n + 2'd1;
        phase_next = hrt_pkg::PH_WSKEY;
      end
      hrt_pkg::PH_WSKEY: do_key = 1'b1;
      hrt_pkg::PH_KEY: begin
        if (in_byte == hrt_pkg::CH_COLON) begin
          tok[n[0]]  = hrt_pkg::mk_result(hrt_pkg::TK_KEY_END, 8'd0, 3'd0, 8'd0, 8'd0);
          n          = n + 2'd1;
          phase_next = hrt_pkg::PH_WSVAL;
        end else begin
          tok[n[0]] = hrt_pkg::mk_result(hrt_pkg::TK_KEY_BYTE, in_byte, 3'd0, 8'd0, 8'd0);
          n         = n + 2'd1;
        end
      end
      hrt_pkg::PH_WSVAL: begin
        if (!hrt_pkg::is_ws(in_byte)) begin
          phase_next = hrt_pkg::PH_VALUE;
          do_value   = 1'b1;
        end
      end
      hrt_pkg::PH_VALUE: do_value = 1'b1;
      hrt_pkg::PH_END1: begin
        if (in_byte == hrt_pkg::CH_CR) phase_next = hrt_pkg::PH_END2;
        else do_key = 1'b1;
      end
      hrt_pkg::PH_END2: begin
        if (in_byte == hrt_pkg::CH_LF) begin
          tok[n[0]]  = hrt_pkg::mk_result(hrt_pkg::TK_HEADER_END, 8'd0, 3'd0, 8'd0, 8'd0);
          n          = n + 2'd1;
          phase_next = hrt_pkg::PH_BODY;
        end else begin
          do_key = 1'b1;
        end
      end
      hrt_pkg::PH_BODY: begin
        tok[n[0]] = hrt_pkg::mk_result(hrt_pkg::TK_BODY, in_byte, 3'd0, 8'd0, 8'd0);
        n         = n + 2'd1;
      end
      default: phase_next = hrt_pkg::PH_METHOD;
    endcase

    // start of a header key, possibly after blank lines or whitespace
    if (do_key) begin
      if (hrt_pkg::is_ws(in_byte)) begin
        phase_next = hrt_pkg::PH_WSKEY;
      end else if (in_byte == hrt_pkg::CH_COLON) begin
        tok[n[0]]  = hrt_pkg::mk_result(hrt_pkg::TK_KEY_END, 8'd0, 3'd0, 8'd0, 8'd0);
        n          = n + 2'd1;
        phase_next = hrt_pkg::PH_WSVAL;
      end else begin
        tok[n[0]]  = hrt_pkg::mk_result(hrt_pkg::TK_KEY_BYTE, in_byte, 3'd0, 8'd0, 8'd0);
        n          = n + 2'd1;
        phase_next = hrt_pkg::PH_KEY;
      end
    end

    // value byte; a CR is held back until we know whether LF follows
    if (do_value) begin
      if (in_byte == hrt_pkg::CH_LF) begin
        tok[n[0]] = hrt_pkg::mk_result(hrt_pkg::TK_VALUE_END, 8'd0, 3'd0, 8'd0, 8'd0);
        n         = n + 2'd1;
        if (held_cr) begin
          held_cr_next = 1'b0;
          phase_next   = hrt_pkg::PH_END1;
        end else begin
          phase_next = hrt_pkg::PH_WSKEY;
        end
      end else if (held_cr) begin
        tok[n[0]] = hrt_pkg::mk_result(hrt_pkg::TK_VALUE_BYTE, hrt_pkg::CH_CR,
                                       3'd0, 8'd0, 8'd0);
        n         = n + 2'd1;
        if (in_byte != hrt_pkg::CH_CR) begin
          held_cr_next = 1'b0;
          tok[n[0]]    = hrt_pkg::mk_result(hrt_pkg::TK_VALUE_BYTE, in_byte,
                                            3'd0, 8'd0, 8'd0);
          n            = n + 2'd1;
        end
      end else if (in_byte == hrt_pkg::CH_CR) begin
        held_cr_next = 1'b1;
      end else begin
        tok[n[0]] = hrt_pkg::mk_result(hrt_pkg::TK_VALUE_BYTE, in_byte, 3'd0, 8'd0, 8'd0);
        n         = n + 2'd1;
      end
    end

    if (in_end && n == 2'd0) begin
      tok[0] = hrt_pkg::mk_result(hrt_pkg::TK_NONE, 8'd0, 3'd0, 8'd0, 8'd0);
      n      = 2'd1;
    end

    if (n != 2'd0) begin
      tok[n[1]].last = 1'b1;
      if (in_end) begin
        tok[n[1]].done = 1'b1;
        if (seen_next < min_len)                tok[n[1]].status = hrt_pkg::ST_SHORT;
        else if (phase_next != hrt_pkg::PH_BODY) tok[n[1]].status = hrt_pkg::ST_TRUNC;
        else                                    tok[n[1]].status = hrt_pkg::ST_OK;
      end
    end

    if (in_end) begin
      phase_next    = hrt_pkg::PH_METHOD;
      skip_cnt_next = 3'd0;
      match_next    = 4'hF;
      mlen_next     = 4'd0;
      major_next    = 8'd0;
      minor_next    = 8'd0;
      held_cr_next  = 1'b0;
      seen_next     = 8'd0;
    end
  end

  assign res_count = n;
  assign res0      = tok[0];
  assign res1      = tok[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len  <= hrt_pkg::MIN_LEN_RESET;
      phase    <= hrt_pkg::PH_METHOD;
      skip_cnt <= 3'd0;
      match    <= 4'hF;
      mlen     <= 4'd0;
      major    <= 8'd0;
      minor    <= 8'd0;
      held_cr  <= 1'b0;
      seen     <= 8'd0;
    end else begin
      if (cfg_valid) min_len <= cfg_data;
      if (in_take) begin
        phase    <= phase_next;
        skip_cnt <= skip_cnt_next;
        match    <= match_next;
        mlen     <= mlen_next;
        major    <= major_next;
        minor    <= minor_next;
        held_cr  <= held_cr_next;
        seen     <= seen_next;
      end
    end
  end

endmodule

// ===== rtl/core/hrt_out_fifo.sv =====
// Small result queue: takes up to two results per cycle, gives one per cycle while rd_ready is high.
module hrt_out_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        wr_count,
  input  hrt_pkg::result_t  wr0,
  input  hrt_pkg::result_t  wr1,
  output logic              room_two,
  output logic              rd_valid,
  output hrt_pkg::result_t  rd_data,
  input  logic              rd_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 1;

  hrt_pkg::result_t mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             pop;

  assign rd_valid = (count != '0);
  assign rd_data  = mem[rptr];
  assign pop      = rd_valid && rd_ready;
  assign room_two = (count <= CW'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) mem[wptr] <= wr0;
    if (wr_count == 2'd2) mem[wptr + AW'(1)] <= wr1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + AW'(wr_count);
      if (pop) rptr <= rptr + AW'(1);
      count <= count + CW'(wr_count) - CW'(pop);
    end
  end

endmodule

// ===== dv/http_request_header_tokenizer_checker.sv =====
// Checker for the HTTP request header tokenizer: predicts the token stream and compares it.
`timescale 1ns / 1ps
module http_request_header_tokenizer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_request
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] token_byte, [10:8] method_code, [18:11] version_major,
  // [26:19] version_minor, [28:27] request_status, [29] request_done, [31:30] zero
  input  logic [31:0] m_axis_tdata,
  input  logic [3:0]  m_axis_tuser,   // [3:0] token_kind
  input  logic        m_axis_tlast,   // last_result
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        run_done,
  output int          error_count,
  output int          tokens_pending,
  output int          tokens_checked
);

  localparam int PRINT_CAP = 40;

  logic [7:0]       min_len;
  hrt_pkg::phase_t  phase;
  logic [2:0]       skip_cnt;
  logic [3:0]       match_bits;
  logic [3:0]       meth_len;
  logic [7:0]       major_d;
  logic [7:0]       minor_d;
  logic             cr_held;
  logic [7:0]       byte_count;

  hrt_pkg::result_t expected_tokens[$];
  hrt_pkg::result_t step_tokens[$];

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("checker: token %0d: %s", tokens_checked, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      note_error($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  function automatic bit is_blank(input logic [7:0] b);
    case (b) inside
      hrt_pkg::CH_SP, hrt_pkg::CH_LF, hrt_pkg::CH_CR, hrt_pkg::CH_TAB: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic string method_text(input int m);
    case (m)
      0: return "GET";
      1: return "POST";
      2: return "DELETE";
      default: return "PUT";
    endcase
  endfunction

  function automatic logic [2:0] method_id(input int m);
    case (m)
      0: return hrt_pkg::MC_GET;
      1: return hrt_pkg::MC_POST;
      2: return hrt_pkg::MC_DELETE;
      default: return hrt_pkg::MC_PUT;
    endcase
  endfunction

  function automatic void add_token(input hrt_pkg::kind_t k, input logic [7:0] d);
    hrt_pkg::result_t t;
    t = '0;
    t.kind = k;
    t.data = d;
    step_tokens.push_back(t);
  endfunction

  function automatic void add_version();
    hrt_pkg::result_t t;
    t = '0;
    t.kind = hrt_pkg::TK_VERSION;
    t.major = major_d;
    t.minor = minor_d;
    step_tokens.push_back(t);
  endfunction

  function automatic void clear_parse();
    phase = hrt_pkg::PH_METHOD;
    skip_cnt = '0;
    match_bits = 4'hF;
    meth_len = '0;
    major_d = '0;
    minor_d = '0;
    cr_held = 1'b0;
    byte_count = '0;
  endfunction

  task automatic method_step(input logic [7:0] b);
    hrt_pkg::result_t t;
    string name;
    logic [2:0] code;
    if (b == hrt_pkg::CH_SP) begin
      code = hrt_pkg::MC_UNKNOWN;
      for (int i = 0; i < hrt_pkg::NUM_METHODS; i++) begin
        name = method_text(i);
        if (match_bits[i] && meth_len == name.len()) code = method_id(i);
      end
      t = '0;
      t.kind = hrt_pkg::TK_METHOD;
      t.code = code;
      step_tokens.push_back(t);
      phase = hrt_pkg::PH_PATH;
    end else begin
      for (int i = 0; i < hrt_pkg::NUM_METHODS; i++) begin
        name = method_text(i);
        if (meth_len >= name.len() || name[meth_len] != b) match_bits[i] = 1'b0;
      end
      if (meth_len < hrt_pkg::METHOD_LEN_SAT) meth_len++;
    end
  endtask

  task automatic key_begin(input logic [7:0] b);
    if (is_blank(b)) begin
      phase = hrt_pkg::PH_WSKEY;
    end else if (b == hrt_pkg::CH_COLON) begin
      add_token(hrt_pkg::TK_KEY_END, 8'h00);
      phase = hrt_pkg::PH_WSVAL;
    end else begin
      add_token(hrt_pkg::TK_KEY_BYTE, b);
      phase = hrt_pkg::PH_KEY;
    end
  endtask

  // a CR inside a value waits to see whether LF follows
  task automatic value_step(input logic [7:0] b);
    if (b == hrt_pkg::CH_LF) begin
      add_token(hrt_pkg::TK_VALUE_END, 8'h00);
      if (cr_held) begin
        cr_held = 1'b0;
        phase = hrt_pkg::PH_END1;
      end else begin
        phase = hrt_pkg::PH_WSKEY;
      end
    end else if (cr_held) begin
      add_token(hrt_pkg::TK_VALUE_BYTE, hrt_pkg::CH_CR);
      if (b != hrt_pkg::CH_CR) begin
        cr_held = 1'b0;
        add_token(hrt_pkg::TK_VALUE_BYTE, b);
      end
    end else if (b == hrt_pkg::CH_CR) begin
      cr_held = 1'b1;
    end else begin
      add_token(hrt_pkg::TK_VALUE_BYTE, b);
    end
  endtask

  task automatic predict_tokens(input logic [7:0] b, input logic fin);
    hrt_pkg::result_t t;
    int n;
    step_tokens.delete();
    if (byte_count != 8'hFF) byte_count++;
    case (phase)
      hrt_pkg::PH_METHOD: method_step(b);
      hrt_pkg::PH_PATH: begin
        if (b == hrt_pkg::CH_SP) begin
          add_token(hrt_pkg::TK_PATH_END, 8'h00);
          phase = hrt_pkg::PH_PREFIX;
          skip_cnt = '0;
        end else begin
          add_token(hrt_pkg::TK_PATH_BYTE, b);
        end
      end
      hrt_pkg::PH_PREFIX: begin
        skip_cnt = skip_cnt + 3'd1;
        if (skip_cnt >= hrt_pkg::PREFIX_BYTES) phase = hrt_pkg::PH_MAJOR;
      end
      hrt_pkg::PH_MAJOR: begin
        major_d = b - hrt_pkg::CH_ZERO;
        phase = hrt_pkg::PH_DOT;
      end
      hrt_pkg::PH_DOT: begin
        // without a dot this byte is swallowed
        if (b == hrt_pkg::CH_DOT) begin
          phase = hrt_pkg::PH_MINOR;
        end else begin
          minor_d = '0;
          add_version();
          phase = hrt_pkg::PH_WSKEY;
        end
      end
      hrt_pkg::PH_MINOR: begin
        minor_d = b - hrt_pkg::CH_ZERO;
        add_version();
        phase = hrt_pkg::PH_WSKEY;
      end
      hrt_pkg::PH_WSKEY: key_begin(b);
      hrt_pkg::PH_KEY: begin
        if (b == hrt_pkg::CH_COLON) begin
          add_token(hrt_pkg::TK_KEY_END, 8'h00);
          phase = hrt_pkg::PH_WSVAL;
        end else begin
          add_token(hrt_pkg::TK_KEY_BYTE, b);
        end
      end
      hrt_pkg::PH_WSVAL: begin
        if (!is_blank(b)) begin
          phase = hrt_pkg::PH_VALUE;
          value_step(b);
        end
      end
      hrt_pkg::PH_VALUE: value_step(b);
      hrt_pkg::PH_END1: begin
        if (b == hrt_pkg::CH_CR) phase = hrt_pkg::PH_END2;
        else key_begin(b);
      end
      hrt_pkg::PH_END2: begin
        if (b == hrt_pkg::CH_LF) begin
          add_token(hrt_pkg::TK_HEADER_END, 8'h00);
          phase = hrt_pkg::PH_BODY;
        end else begin
          key_begin(b);
        end
      end
      hrt_pkg::PH_BODY: add_token(hrt_pkg::TK_BODY, b);
      default: phase = hrt_pkg::PH_METHOD;
    endcase

    if (fin && step_tokens.size() == 0) add_token(hrt_pkg::TK_NONE, 8'h00);

    n = step_tokens.size();
    if (n > 0) begin
      t = step_tokens[n-1];
      t.last = 1'b1;
      if (fin) begin
        t.done = 1'b1;
        if (byte_count < min_len) t.status = hrt_pkg::ST_SHORT;
        else if (phase != hrt_pkg::PH_BODY) t.status = hrt_pkg::ST_TRUNC;
        else t.status = hrt_pkg::ST_OK;
      end
      step_tokens[n-1] = t;
    end
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);

    if (fin) clear_parse();
  endtask

  task automatic check_token();
    hrt_pkg::result_t want;
    if (expected_tokens.size() == 0) begin
      note_error($sformatf("unexpected token, kind %0d data %0h", m_axis_tuser,
                           m_axis_tdata));
    end else begin
      want = expected_tokens.pop_front();
      compare_field("token_kind", m_axis_tuser, want.kind);
      compare_field("token_byte", m_axis_tdata[7:0], want.data);
      compare_field("method_code", m_axis_tdata[10:8], want.code);
      compare_field("version_major", m_axis_tdata[18:11], want.major);
      compare_field("version_minor", m_axis_tdata[26:19], want.minor);
      compare_field("request_status", m_axis_tdata[28:27], want.status);
      compare_field("request_done", m_axis_tdata[29], want.done);
      compare_field("pad bits", m_axis_tdata[31:30], 2'b00);
      compare_field("last_result", m_axis_tlast, want.last);
      tokens_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      min_len = hrt_pkg::MIN_LEN_RESET;
      clear_parse();
      expected_tokens.delete();
      error_count = 0;
      tokens_checked = 0;
    end else begin
      // results of a byte appear no earlier than the next cycle, so check first
      if (m_axis_tvalid && m_axis_tready) check_token();
      if (cfg_valid && cfg_ready) min_len = cfg_data;
      if (s_axis_tvalid && s_axis_tready) predict_tokens(s_axis_tdata, s_axis_tlast);
    end
    tokens_pending = expected_tokens.size();
  end

  always @(posedge run_done) begin
    if (expected_tokens.size() != 0)
      note_error($sformatf("%0d tokens never arrived", expected_tokens.size()));
  end

endmodule

// ===== dv/tb_http_request_header_tokenizer.sv =====
// Testbench top for the HTTP request header tokenizer: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_http_request_header_tokenizer;

  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_BYTES  = 160;
  localparam int DRAIN_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;
  logic        run_done = 1'b0;

  int error_count;
  int tokens_pending;
  int tokens_checked;

  bit sender_idles = 1'b0;
  bit receiver_idles = 1'b0;
  int byte_total = 0;
  int request_total = 0;
  int setting_total = 1;
  int quiet_cycles = 0;

  logic [7:0] request_bytes[$];

  always #5 clk = ~clk;

  http_request_header_tokenizer u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  http_request_header_tokenizer_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .run_done      (run_done),
    .error_count   (error_count),
    .tokens_pending(tokens_pending),
    .tokens_checked(tokens_checked)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("http_request_header_tokenizer: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver back-pressure
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        stall = gap_length() - 1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // entered and left at a falling edge; tvalid stays high for a back-to-back byte
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = gap_length();
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tlast = fin;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    byte_total++;
    if (fin) request_total++;
  endtask

  task automatic send_text(input string s, input bit ends);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], ends && i == s.len() - 1);
  endtask

  task automatic send_request();
    foreach (request_bytes[i]) send_byte(request_bytes[i], i == request_bytes.size() - 1);
  endtask

  // block must be idle: wait out every pending token and the queue latency
  task automatic write_min_len(input logic [7:0] v);
    s_axis_tvalid = 1'b0;
    s_axis_tlast = 1'b0;
    while (tokens_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    setting_total++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) request_bytes.push_back(s[i]);
  endtask

  task automatic push_letters(input int n);
    repeat (n) request_bytes.push_back(8'($urandom_range("A", "Z")));
  endtask

  task automatic push_blanks(input int n, input bit with_lf);
    repeat (n) begin
      case ($urandom_range(0, with_lf ? 2 : 1))
        0: request_bytes.push_back(hrt_pkg::CH_SP);
        1: request_bytes.push_back(hrt_pkg::CH_TAB);
        default: request_bytes.push_back(hrt_pkg::CH_LF);
      endcase
    end
  endtask

  task automatic compose_request();
    logic [7:0] b;
    int pick;
    request_bytes.delete();
    pick = $urandom_range(0, 6);
    case (pick)
      0: push_text("GET");
      1: push_text("POST");
      2: push_text("DELETE");
      3: push_text("PUT");
      4: push_letters($urandom_range(0, 12));
      5: begin
        if ($urandom_range(0, 1)) push_text("POS");
        else push_text("DELET");
        push_letters($urandom_range(0, 2));
      end
      default: push_letters($urandom_range(7, 12));
    endcase
    request_bytes.push_back(hrt_pkg::CH_SP);

    request_bytes.push_back("/");
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(8'h00, 8'h1F));
      else b = 8'($urandom_range(8'h21, 8'hFF));
      request_bytes.push_back(b);
    end
    request_bytes.push_back(hrt_pkg::CH_SP);

    if ($urandom_range(0, 7) == 0) begin
      repeat (5) request_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      push_text("HTTP/");
    end
    if ($urandom_range(0, 9) == 0) request_bytes.push_back(8'($urandom_range(0, 255)));
    else request_bytes.push_back(hrt_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 1)) begin
      request_bytes.push_back(hrt_pkg::CH_DOT);
      if ($urandom_range(0, 9) == 0) request_bytes.push_back(8'($urandom_range(0, 255)));
      else request_bytes.push_back(hrt_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
    push_text("\r\n");

    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0) push_blanks($urandom_range(1, 2), 1'b0);
      repeat ($urandom_range(1, 5)) begin
        b = 8'($urandom_range(8'h21, 8'hFF));
        if (b == hrt_pkg::CH_COLON) b = "k";
        request_bytes.push_back(b);
      end
      request_bytes.push_back(hrt_pkg::CH_COLON);
      push_blanks($urandom_range(0, 2), 1'b1);
      // CRs inside a value exercise the held carriage return
      repeat ($urandom_range(0, 8)) begin
        if ($urandom_range(0, 5) == 0) request_bytes.push_back(hrt_pkg::CH_CR);
        else request_bytes.push_back(8'($urandom_range(8'h20, 8'hFF)));
      end
      push_text("\r\n");
    end
    push_text("\r\n");
    repeat ($urandom_range(0, 6)) request_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int start_bytes;
    int pick;
    int cut;
    logic [7:0] setting;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: silent final byte, empty method, saturated method length,
    // DELETE with a top-value path byte, PUT ending on its space
    send_byte(8'h00, 1'b1);
    send_text(" ", 1'b1);
    send_text("ABCDEFGHIJ ", 1'b1);
    send_text("DELETE ", 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("PUT ", 1'b1);

    for (int phase_idx = 0; phase_idx < 5; phase_idx++) begin
      case (phase_idx)
        0: setting = 8'd0;
        1: setting = 8'd255;
        2: setting = 8'($urandom_range(2, 254));
        3: setting = hrt_pkg::MIN_LEN_RESET;
        default: setting = 8'd1;
      endcase
      write_min_len(setting);
      sender_idles = (phase_idx == 1 || phase_idx == 2 || phase_idx == 4);
      receiver_idles = (phase_idx == 1 || phase_idx == 3 || phase_idx == 4);
      start_bytes = byte_total;
      while (byte_total - start_bytes < PHASE_BYTES) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          request_bytes.delete();
          repeat ($urandom_range(1, 12)) request_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
          compose_request();
          if (pick == 1) begin
            cut = $urandom_range(0, request_bytes.size() - 1);
            request_bytes = request_bytes[0:cut];
          end
        end
        send_request();
      end
    end

    s_axis_tvalid = 1'b0;
    s_axis_tlast = 1'b0;
    while (tokens_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    run_done = 1'b1;
    @(negedge clk);

    $display("Sent %0d request bytes in %0d requests across %0d minimum-length settings,",
             byte_total, request_total, setting_total);
    $display("with idle gaps and back-pressure on both sides; %0d tokens compared.",
             tokens_checked);
    if (error_count == 0) begin
      $display("http_request_header_tokenizer: match");
    end else begin
      $display("http_request_header_tokenizer: mismatch");
    end
    $finish;
  end

endmodule
